// ===== src/cell_voltage_calibration_core_defines.svh =====
// ----------------------------------------------------------------------------
// Cell voltage calibration: assertion macros
// Shared concurrent assertion forms used by the calibration core.
// ----------------------------------------------------------------------------
`ifndef CELL_VOLTAGE_CALIBRATION_CORE_DEFINES_SVH
`define CELL_VOLTAGE_CALIBRATION_CORE_DEFINES_SVH

// same-cycle implication
`define CVC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/cvc_pkg.sv =====
// ----------------------------------------------------------------------------
// Cell voltage calibration package
// Widths, constants, register codes and shared types of the calibration core.
// ----------------------------------------------------------------------------
`default_nettype none

package cvc_pkg;

    localparam int NUM_CELLS   = 6;
    localparam int GAIN_BASE   = 1000;
    localparam int DIV_SCALE   = 600000;

    localparam int CH_W        = 3;
    localparam int READ_W      = 16;
    localparam int VOLT_W      = 16;
    localparam int CORR_W      = 5;
    localparam int VGAIN_W     = 5;
    localparam int VOFF_W      = 6;
    localparam int PACK_W      = 30;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 4;

    localparam int FAC_W       = 10;  // 1000 + correction, always 984..1015
    localparam int P1_W        = 26;  // (1000+gr) * vref
    localparam int OCV_W       = 22;  // oc * vref, signed
    localparam int D_W         = 36;  // 600000 * vref
    localparam int PROD_W      = 43;  // vcell * (p1 + or)
    localparam int NUM1_W      = 44;  // signed first numerator
    localparam int MAG_W       = 42;  // magnitude of a nonnegative first numerator
    localparam int HALF_W      = 21;  // split point of the gain multiply
    localparam int PP_W        = 31;  // partial product width
    localparam int QUOT_W      = 17;  // 16 result bits plus saturation bit
    localparam int REM_W       = 52;  // full numerator / shifted divisor
    localparam int DIV_CELLS   = QUOT_W;

    typedef enum logic [1:0] {
        REG_CELL_GAIN   = 2'd0,
        REG_CELL_OFFSET = 2'd1,
        REG_VREF_GAIN   = 2'd2,
        REG_VREF_OFFSET = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [PACK_W-1:0]  cell_gain_pack;
        logic [PACK_W-1:0]  cell_offset_pack;
        logic [VGAIN_W-1:0] ref_gain_corr;
        logic [VOFF_W-1:0]  ref_offset_corr;
    } t_cfg;

    // data handed from one divider cell to the next
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [REM_W-1:0]  dsh;
        logic [QUOT_W-1:0] quot;
        logic              zero;
        logic              err;
    } t_div_data;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage;
        logic              err;
    } t_result;

    function automatic logic [CORR_W-1:0] cell_corr(input logic [PACK_W-1:0] pack,
                                                     input logic [CH_W-1:0]   ch);
        logic [CORR_W-1:0] v;
        v = '0;
        for (int k = 0; k < NUM_CELLS; k++) begin
            if (ch == CH_W'(k + 1)) begin
                v = pack[k*CORR_W +: CORR_W];
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/cvc_ifs.sv =====
// ----------------------------------------------------------------------------
// Cell voltage calibration channels
// Valid/ready interfaces for the reading input and the result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface cvc_in_if;
    logic                        valid;
    logic                        ready;
    logic [cvc_pkg::CH_W-1:0]    cell_channel;
    logic [cvc_pkg::READ_W-1:0]  cell_reading;
    logic [cvc_pkg::READ_W-1:0]  ref_reading;

    modport source (output valid, cell_channel, cell_reading, ref_reading, input ready);
    modport sink   (input valid, cell_channel, cell_reading, ref_reading, output ready);
endinterface

interface cvc_out_if;
    logic                        valid;
    logic                        ready;
    logic [cvc_pkg::VOLT_W-1:0]  cell_voltage;
    logic                        error_flag;

    modport source (output valid, cell_voltage, error_flag, input ready);
    modport sink   (input valid, cell_voltage, error_flag, output ready);
endinterface

`default_nettype wire

// ===== src/cvc_apb_regs.sv =====
// ----------------------------------------------------------------------------
// Calibration register file
// APB-style write/read access to the four correction registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cvc_apb_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cvc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [cvc_pkg::DATA_W-1:0]    pwdata,
    output logic      [cvc_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    output cvc_pkg::t_cfg                      o_cfg
);

    cvc_pkg::t_cfg    r_cfg;
    cvc_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = cvc_pkg::t_reg_idx'(paddr[cvc_pkg::ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_idx)
                cvc_pkg::REG_CELL_GAIN:   r_cfg.cell_gain_pack   <= pwdata[cvc_pkg::PACK_W-1:0];
                cvc_pkg::REG_CELL_OFFSET: r_cfg.cell_offset_pack <= pwdata[cvc_pkg::PACK_W-1:0];
                cvc_pkg::REG_VREF_GAIN:   r_cfg.ref_gain_corr    <= pwdata[cvc_pkg::VGAIN_W-1:0];
                cvc_pkg::REG_VREF_OFFSET: r_cfg.ref_offset_corr  <= pwdata[cvc_pkg::VOFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            cvc_pkg::REG_CELL_GAIN:   prdata = cvc_pkg::DATA_W'(r_cfg.cell_gain_pack);
            cvc_pkg::REG_CELL_OFFSET: prdata = cvc_pkg::DATA_W'(r_cfg.cell_offset_pack);
            cvc_pkg::REG_VREF_GAIN:   prdata = cvc_pkg::DATA_W'(r_cfg.ref_gain_corr);
            cvc_pkg::REG_VREF_OFFSET: prdata = cvc_pkg::DATA_W'(r_cfg.ref_offset_corr);
            default:                  prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/cvc_front.sv =====
// ----------------------------------------------------------------------------
// Calibration numerator pipeline
// Four stages that form the corrected numerator and the shifted divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module cvc_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [cvc_pkg::CH_W-1:0]      i_ch,
    input  wire logic [cvc_pkg::READ_W-1:0]    i_vc,
    input  wire logic [cvc_pkg::READ_W-1:0]    i_vr,
    input  cvc_pkg::t_cfg                      i_cfg,
    output logic                               o_valid,
    output cvc_pkg::t_div_data                 o_data
);

    typedef struct packed {
        logic                         err;
        logic [cvc_pkg::READ_W-1:0]   vc;
        logic [cvc_pkg::P1_W-1:0]     p1;
        logic [cvc_pkg::OCV_W-1:0]    ocv;
        logic [cvc_pkg::D_W-1:0]      dd;
        logic [cvc_pkg::VOFF_W-1:0]   vref_off;
        logic [cvc_pkg::CORR_W-1:0]   gc;
    } t_stage_a;

    typedef struct packed {
        logic                         err;
        logic [cvc_pkg::NUM1_W-1:0]   num1;
        logic [cvc_pkg::D_W-1:0]      dd;
        logic [cvc_pkg::CORR_W-1:0]   gc;
    } t_stage_b;

    typedef struct packed {
        logic                         err;
        logic                         zero;
        logic [cvc_pkg::PP_W-1:0]     pp_lo;
        logic [cvc_pkg::PP_W-1:0]     pp_hi;
        logic [cvc_pkg::D_W-1:0]      dd;
    } t_stage_c;

    logic r_va, r_vb, r_vc, r_vd;
    t_stage_a r_a;
    t_stage_b r_b;
    t_stage_c r_c;
    cvc_pkg::t_div_data r_d;

    // stage A inputs
    logic [cvc_pkg::CORR_W-1:0]        w_gc, w_oc;
    logic [cvc_pkg::FAC_W-1:0]         w_gr_fac;
    logic signed [cvc_pkg::OCV_W-1:0]  w_ocv;
    logic                              w_err;
    // stage B
    logic signed [cvc_pkg::P1_W+1:0]   w_t;
    logic [cvc_pkg::PROD_W-1:0]        w_prod;
    logic signed [cvc_pkg::NUM1_W-1:0] w_num1;
    // stage C
    logic [cvc_pkg::FAC_W-1:0]         w_gain;

    always_comb begin
        w_gc     = cvc_pkg::cell_corr(i_cfg.cell_gain_pack, i_ch);
        w_oc     = cvc_pkg::cell_corr(i_cfg.cell_offset_pack, i_ch);
        w_gr_fac = cvc_pkg::FAC_W'((cvc_pkg::FAC_W+1)'(cvc_pkg::GAIN_BASE)
                   + (cvc_pkg::FAC_W+1)'($signed(i_cfg.ref_gain_corr)));
        w_ocv    = cvc_pkg::OCV_W'($signed(w_oc)) * cvc_pkg::OCV_W'($signed({1'b0, i_vr}));
        w_err    = (i_ch == '0) || (i_ch > cvc_pkg::CH_W'(cvc_pkg::NUM_CELLS))
                   || (i_vr == '0);

        w_t      = $signed({2'b00, r_a.p1}) + (cvc_pkg::P1_W+2)'($signed(r_a.vref_off));
        w_prod   = cvc_pkg::PROD_W'(r_a.vc) * cvc_pkg::PROD_W'(w_t[cvc_pkg::P1_W:0]);
        w_num1   = $signed({1'b0, w_prod}) + cvc_pkg::NUM1_W'($signed(r_a.ocv));

        w_gain   = cvc_pkg::FAC_W'((cvc_pkg::FAC_W+1)'(cvc_pkg::GAIN_BASE)
                   + (cvc_pkg::FAC_W+1)'($signed(r_b.gc)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a.err      <= w_err;
            r_a.vc       <= i_vc;
            r_a.p1       <= cvc_pkg::P1_W'(w_gr_fac) * cvc_pkg::P1_W'(i_vr);
            r_a.ocv      <= w_ocv;
            r_a.dd       <= cvc_pkg::D_W'(cvc_pkg::DIV_SCALE) * cvc_pkg::D_W'(i_vr);
            r_a.vref_off <= i_cfg.ref_offset_corr;
            r_a.gc       <= w_gc;

            r_b.err  <= r_a.err;
            r_b.num1 <= w_num1;
            r_b.dd   <= r_a.dd;
            r_b.gc   <= r_a.gc;

            // a negative numerator always ends as zero, so only its magnitude matters
            r_c.err   <= r_b.err;
            r_c.zero  <= r_b.err || r_b.num1[cvc_pkg::NUM1_W-1];
            r_c.pp_lo <= cvc_pkg::PP_W'(r_b.num1[cvc_pkg::HALF_W-1:0])
                         * cvc_pkg::PP_W'(w_gain);
            r_c.pp_hi <= cvc_pkg::PP_W'(r_b.num1[cvc_pkg::MAG_W-1:cvc_pkg::HALF_W])
                         * cvc_pkg::PP_W'(w_gain);
            r_c.dd    <= r_b.dd;

            r_d.rem  <= (cvc_pkg::REM_W'(r_c.pp_hi) << cvc_pkg::HALF_W)
                        + cvc_pkg::REM_W'(r_c.pp_lo);
            r_d.dsh  <= cvc_pkg::REM_W'({r_c.dd, {(cvc_pkg::QUOT_W-1){1'b0}}});
            r_d.quot <= '0;
            r_d.zero <= r_c.zero;
            r_d.err  <= r_c.err;
        end
    end

    assign o_valid = r_vd;
    assign o_data  = r_d;

endmodule

`default_nettype wire

// ===== src/cvc_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step: compare, conditional subtract, one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module cvc_div_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  cvc_pkg::t_div_data    i_data,
    output logic                  o_valid,
    output cvc_pkg::t_div_data    o_data
);

    logic               r_valid;
    cvc_pkg::t_div_data r_data;
    cvc_pkg::t_div_data n_data;
    logic               w_ge;

    always_comb begin
        w_ge        = i_data.rem >= i_data.dsh;
        n_data      = i_data;
        n_data.rem  = w_ge ? (i_data.rem - i_data.dsh) : i_data.rem;
        n_data.dsh  = i_data.dsh >> 1;
        n_data.quot = {i_data.quot[cvc_pkg::QUOT_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== src/cvc_div_chain.sv =====
// ----------------------------------------------------------------------------
// Divider cell row
// Row of restoring cells, most significant quotient bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module cvc_div_chain (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  cvc_pkg::t_div_data    i_data,
    output logic                  o_valid,
    output cvc_pkg::t_result      o_res
);

    logic               w_v [cvc_pkg::DIV_CELLS+1];
    cvc_pkg::t_div_data w_d [cvc_pkg::DIV_CELLS+1];
    cvc_pkg::t_div_data w_last;

    assign w_v[0] = i_valid;
    assign w_d[0] = i_data;

    for (genvar g = 0; g < cvc_pkg::DIV_CELLS; g++) begin : g_cell
        cvc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_v[g]),
            .i_data  (w_d[g]),
            .o_valid (w_v[g+1]),
            .o_data  (w_d[g+1])
        );
    end

    assign w_last  = w_d[cvc_pkg::DIV_CELLS];
    assign o_valid = w_v[cvc_pkg::DIV_CELLS];

    // top quotient bit set means the quotient reached 65536 or more
    always_comb begin
        o_res.err = w_last.err;
        if (w_last.zero) begin
            o_res.voltage = '0;
        end else if (w_last.quot[cvc_pkg::QUOT_W-1]) begin
            o_res.voltage = '1;
        end else begin
            o_res.voltage = w_last.quot[cvc_pkg::VOLT_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== src/cell_voltage_calibration_core.sv =====
// ----------------------------------------------------------------------------
// Cell voltage calibration core
// Gain/offset corrected cell voltage from a raw cell and reference reading.
// ----------------------------------------------------------------------------
// Takes one reading per clock while input ready is high and returns one result
// per reading, in order. A reading passes four numerator stages, a row of 17
// divider cells that each settle one quotient bit, and the output register.
// The fully pipelined divider row sets the sustained rate of one item per cycle.
// An untaken result waits in the output register while one more lands in a skid
// register; input ready drops only when the skid is full. Corrections must be
// written through the APB port only while idle, which the core does not enforce.
`default_nettype none

`include "cell_voltage_calibration_core_defines.svh"

module cell_voltage_calibration_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    cvc_in_if.sink                             i_in,
    cvc_out_if.source                          o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cvc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [cvc_pkg::DATA_W-1:0]    pwdata,
    output logic      [cvc_pkg::DATA_W-1:0]    prdata,
    output logic                               pready
);

    cvc_pkg::t_cfg      w_cfg;
    logic               w_en;
    logic               w_front_v;
    cvc_pkg::t_div_data w_front_d;
    logic               w_last_v;
    cvc_pkg::t_result   w_res;
    logic               w_out_free;

    logic               r_out_v, r_skid_v;
    cvc_pkg::t_result   r_out, r_skid;

    cvc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // whole pipeline moves together; it halts only while the skid holds a result
    assign w_en       = !r_skid_v;
    assign i_in.ready = w_en;

    cvc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_ch    (i_in.cell_channel),
        .i_vc    (i_in.cell_reading),
        .i_vr    (i_in.ref_reading),
        .i_cfg   (w_cfg),
        .o_valid (w_front_v),
        .o_data  (w_front_d)
    );

    cvc_div_chain u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_v),
        .i_data  (w_front_d),
        .o_valid (w_last_v),
        .o_res   (w_res)
    );

    assign w_out_free = !r_out_v || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= w_last_v && w_en;
            end
        end else if (w_last_v && w_en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_v ? r_skid : w_res;
        end else if (w_last_v && w_en) begin
            r_skid <= w_res;
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.cell_voltage = r_out.voltage;
    assign o_out.error_flag   = r_out.err;

    `CVC_ASSERT_IMPL(a_skid_needs_out, i_clk, i_rst_n, r_skid_v, r_out_v, "skid full, output empty")
    `CVC_ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n, r_skid_v && !o_out.ready, r_skid_v, "skid lost")
    `CVC_ASSERT_NEXT(a_last_holds, i_clk, i_rst_n, w_last_v && !w_en, w_last_v, "result dropped")
    `CVC_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_out.valid && o_out.error_flag, o_out.cell_voltage == '0, "error result nonzero")

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Cell voltage calibration core testbench
// Drives readings through the valid/ready input, programs the corrections over
// APB between phases, and checks every result against an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int          RANDOM_PER_PHASE = 125;
    localparam int          DRAIN_CYCLES     = 30;
    localparam int          LONG_STALL       = 300;
    localparam int          CYCLE_LIMIT      = 200000;
    localparam int          MAX_REPORTS      = 10;
    localparam logic [4:0]  CORR_MIN         = 5'b10000;
    localparam logic [4:0]  CORR_MAX         = 5'b01111;
    localparam logic [31:0] VGAIN_MIN        = 32'h10;
    localparam logic [31:0] VGAIN_MAX        = 32'h0F;
    localparam logic [31:0] VOFF_MIN         = 32'h20;
    localparam logic [31:0] VOFF_MAX         = 32'h1F;

    typedef struct packed {
        logic [cvc_pkg::CH_W-1:0]   ch;
        logic [cvc_pkg::READ_W-1:0] vcell;
        logic [cvc_pkg::READ_W-1:0] vref;
    } t_reading;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [cvc_pkg::ADDR_W-1:0] paddr;
    logic [cvc_pkg::DATA_W-1:0] pwdata;
    logic [cvc_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    cvc_in_if  in_ch ();
    cvc_out_if out_ch ();

    cell_voltage_calibration_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cvc_pkg::t_cfg    cal_cfg;
    t_reading         pending_readings[$];
    cvc_pkg::t_result expected_voltages[$];
    int               send_idle_pct;
    int               recv_stall_pct;
    int               mismatches = 0;
    int               stall_left;
    logic             long_stall_req;
    int               cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // expected result of one reading under the current corrections
    function automatic cvc_pkg::t_result calc_cell_voltage(t_reading r);
        cvc_pkg::t_result res;
        logic [4:0]  g5;
        logic [4:0]  o5;
        longint      gc;
        longint      oc;
        longint      gr;
        longint      orf;
        longint      vc;
        longint      vr;
        longint      num;
        longint      q;
        res = '0;
        if (r.ch < 1 || r.ch > cvc_pkg::NUM_CELLS || r.vref == '0) begin
            res.err = 1'b1;
            return res;
        end
        g5  = cal_cfg.cell_gain_pack[(r.ch - 1) * cvc_pkg::CORR_W +: cvc_pkg::CORR_W];
        o5  = cal_cfg.cell_offset_pack[(r.ch - 1) * cvc_pkg::CORR_W +: cvc_pkg::CORR_W];
        gc  = longint'($signed(g5));
        oc  = longint'($signed(o5));
        gr  = longint'($signed(cal_cfg.ref_gain_corr));
        orf = longint'($signed(cal_cfg.ref_offset_corr));
        vc  = longint'(r.vcell);
        vr  = longint'(r.vref);
        num = vc * ((cvc_pkg::GAIN_BASE + gr) * vr + orf) + oc * vr;
        num = num * (cvc_pkg::GAIN_BASE + gc);
        q   = num / (longint'(cvc_pkg::DIV_SCALE) * vr);
        if (q < 0)     q = 0;
        if (q > 65535) q = 65535;
        res.voltage = q[cvc_pkg::VOLT_W-1:0];
        return res;
    endfunction

    function automatic logic [31:0] pack_cells(logic [4:0] odd_cells, logic [4:0] even_cells);
        logic [31:0] p;
        p = '0;
        for (int k = 0; k < cvc_pkg::NUM_CELLS; k++) begin
            p[k*cvc_pkg::CORR_W +: cvc_pkg::CORR_W] = (k % 2 == 0) ? odd_cells : even_cells;
        end
        return p;
    endfunction

    function automatic t_reading rand_reading();
        t_reading r;
        int       sel;
        sel  = $urandom_range(99);
        r.ch = (sel < 8) ? ($urandom_range(1) ? cvc_pkg::CH_W'(7) : cvc_pkg::CH_W'(0))
                         : cvc_pkg::CH_W'($urandom_range(cvc_pkg::NUM_CELLS, 1));
        sel = $urandom_range(99);
        if (sel < 4)       r.vref = '0;
        else if (sel < 20) r.vref = cvc_pkg::READ_W'($urandom_range(15, 1));
        else if (sel < 30) r.vref = cvc_pkg::READ_W'($urandom_range(65535, 65000));
        else               r.vref = cvc_pkg::READ_W'($urandom);
        sel = $urandom_range(99);
        if (sel < 15)      r.vcell = cvc_pkg::READ_W'($urandom_range(31));
        else if (sel < 30) r.vcell = cvc_pkg::READ_W'($urandom_range(65535, 39000));
        else               r.vcell = cvc_pkg::READ_W'($urandom);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint want, longint got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch (%s) at %0t: expected %0d, got %0d", what, $time, want, got);
        end
    endtask

    task automatic queue_reading(int ch, int vc, int vr);
        pending_readings.push_back(t_reading'{cvc_pkg::CH_W'(ch), cvc_pkg::READ_W'(vc),
                                              cvc_pkg::READ_W'(vr)});
    endtask

    task automatic queue_random(int count);
        for (int k = 0; k < count; k++) begin
            pending_readings.push_back(rand_reading());
        end
    endtask

    // all readings sent and all results back, then let the pipeline settle
    task automatic wait_drained();
        while (pending_readings.size() != 0 || in_ch.valid || expected_voltages.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(cvc_pkg::t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            cvc_pkg::REG_CELL_GAIN:   cal_cfg.cell_gain_pack   = val[cvc_pkg::PACK_W-1:0];
            cvc_pkg::REG_CELL_OFFSET: cal_cfg.cell_offset_pack = val[cvc_pkg::PACK_W-1:0];
            cvc_pkg::REG_VREF_GAIN:   cal_cfg.ref_gain_corr    = val[cvc_pkg::VGAIN_W-1:0];
            cvc_pkg::REG_VREF_OFFSET: cal_cfg.ref_offset_corr  = val[cvc_pkg::VOFF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_corrections(logic [31:0] gains, logic [31:0] offsets,
                                     logic [31:0] vgain, logic [31:0] voff);
        apb_write(cvc_pkg::REG_CELL_GAIN, gains);
        apb_write(cvc_pkg::REG_CELL_OFFSET, offsets);
        apb_write(cvc_pkg::REG_VREF_GAIN, vgain);
        apb_write(cvc_pkg::REG_VREF_OFFSET, voff);
    endtask

    // driver: one transfer per accepted reading
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_voltages.push_back(calc_cell_voltage(
                    t_reading'{in_ch.cell_channel, in_ch.cell_reading, in_ch.ref_reading}));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_readings.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_reading r;
                    r = pending_readings.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.cell_channel <= r.ch;
                    in_ch.cell_reading <= r.vcell;
                    in_ch.ref_reading  <= r.vref;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : result_check
        cvc_pkg::t_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_voltages.size() == 0) begin
                    report_mismatch("result with nothing expected", -1, out_ch.cell_voltage);
                end else begin
                    want = expected_voltages.pop_front();
                    if (out_ch.cell_voltage !== want.voltage) begin
                        report_mismatch("cell_voltage", want.voltage, out_ch.cell_voltage);
                    end
                    if (out_ch.error_flag !== want.err) begin
                        report_mismatch("error_flag", want.err, out_ch.error_flag);
                    end
                end
            end
            out_ch.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, counted down here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left <= 0;
        end else if (long_stall_req) begin
            stall_left <= LONG_STALL;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[cell_voltage_calibration_core] ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        long_stall_req     = 1'b0;
        cal_cfg            = '0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset corrections: every channel, invalid channels, zero ref, clamp edges
        for (int c = 1; c <= cvc_pkg::NUM_CELLS; c++) begin
            queue_reading(c, 12345, 40000);
        end
        queue_reading(0, 1000, 1000);
        queue_reading(7, 1000, 1000);
        queue_reading(3, 5000, 0);
        queue_reading(0, 0, 0);
        queue_reading(1, 0, 1);
        queue_reading(6, 65535, 65535);
        queue_reading(2, 65535, 1);
        queue_reading(4, 39321, 50000);  // lands exactly on full scale
        queue_reading(5, 39322, 50000);  // just over full scale
        wait_drained();

        // most negative corrections: negative quotients clamp to zero
        write_corrections(pack_cells(CORR_MIN, CORR_MIN), pack_cells(CORR_MIN, CORR_MIN),
                          VGAIN_MIN, VOFF_MIN);
        queue_reading(1, 0, 65535);
        queue_reading(2, 0, 1);
        queue_reading(6, 1, 65535);
        queue_reading(3, 65535, 1);
        queue_reading(5, 20000, 30000);
        wait_drained();

        // random corrections, no idling
        write_corrections($urandom, $urandom, $urandom, $urandom);
        queue_random(RANDOM_PER_PHASE);
        wait_drained();

        // largest corrections, sender idles often
        write_corrections(pack_cells(CORR_MAX, CORR_MAX), pack_cells(CORR_MAX, CORR_MAX),
                          VGAIN_MAX, VOFF_MAX);
        send_idle_pct = 65;
        queue_random(RANDOM_PER_PHASE);
        wait_drained();

        // random corrections, receiver stalls and one long hold-off fills the core
        write_corrections($urandom, $urandom, $urandom, $urandom);
        send_idle_pct  = 0;
        recv_stall_pct = 65;
        queue_random(RANDOM_PER_PHASE);
        long_stall_req <= 1'b1;
        @(posedge i_clk);
        long_stall_req <= 1'b0;
        wait_drained();

        // alternating extremes per cell, both sides idle
        write_corrections(pack_cells(CORR_MIN, CORR_MAX), pack_cells(CORR_MAX, CORR_MIN),
                          VGAIN_MIN, VOFF_MAX);
        send_idle_pct  = 23;
        recv_stall_pct = 23;
        queue_random(RANDOM_PER_PHASE);
        wait_drained();

        if (mismatches == 0) begin
            $display("[cell_voltage_calibration_core] OK");
        end else begin
            $display("[cell_voltage_calibration_core] ERROR");
        end
        $finish;
    end

endmodule
